// ===== rtl/mfrf_pkg.sv =====
package mfrf_pkg;

    localparam int NEIGHBOR_SLOTS = 8;
    localparam int TAG_SLOTS      = 32;
    localparam int PAYLOAD_BYTES  = 64;

    localparam int ADDR_W  = 16;
    localparam int TAG_W   = 8;
    localparam int POWER_W = 8;
    localparam int LEN_W   = 7;

    localparam int NB_IDX_W  = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
    localparam int NB_CNT_W  = $clog2(NEIGHBOR_SLOTS + 1);
    localparam int TAG_IDX_W = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
    localparam int TAG_CNT_W = $clog2(TAG_SLOTS + 1);

    localparam logic [ADDR_W-1:0] BCAST_ADDR  = 16'hFFFF;
    localparam logic [ADDR_W-1:0] OWN_RESET   = 16'd1;
    localparam logic [ADDR_W-1:0] ROUTE_RESET = 16'd2;
    localparam logic [LEN_W-1:0]  BCAST_LEN   = 7'd5;
    localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RELAY = 2'd1,
        ACT_BCAST = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_bcast;
        logic scan_done;
    } dp_status_t;

endpackage

// ===== rtl/mesh_frame_relay_filter_core.sv =====
// Mesh frame relay filter: takes one received frame summary per transfer and
// returns one action per result transfer. A frame that is not a broadcast, or one
// addressed to this node, goes from the check state straight to the update state.
// A broadcast frame first scans the neighbour table and the tag table in parallel,
// each a RAM read one entry per cycle, so its time grows with the larger of the
// two table fills. One frame is worked on at a time. The next frame is taken the
// cycle after a result is registered, while that result may still wait. A frame
// that finishes while the previous result is still stalled is held until that
// result is taken.
// own_address may only be written while no frame is in flight.
module mesh_frame_relay_filter_core
    import mfrf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ADDR_W-1:0]  own_address,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [ADDR_W-1:0]  dst_address,
    input  logic [ADDR_W-1:0]  src_address,
    input  logic [ADDR_W-1:0]  final_dest,
    input  logic [ADDR_W-1:0]  route_word,
    input  logic [TAG_W-1:0]   frame_tag,
    input  logic [POWER_W-1:0] signal_power,
    input  logic [LEN_W-1:0]   uplink_length,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         action,
    output logic [ADDR_W-1:0]  next_hop,
    output logic [LEN_W-1:0]   relay_length,
    output logic [ADDR_W-1:0]  relay_delay,
    output logic               neighbor_added,
    output logic               route_changed
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mfrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mfrf_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_own_address (own_address),
        .dst_address     (dst_address),
        .src_address     (src_address),
        .final_dest      (final_dest),
        .route_word      (route_word),
        .frame_tag       (frame_tag),
        .signal_power    (signal_power),
        .uplink_length   (uplink_length),
        .action          (action),
        .next_hop        (next_hop),
        .relay_length    (relay_length),
        .relay_delay     (relay_delay),
        .neighbor_added  (neighbor_added),
        .route_changed   (route_changed)
    );

endmodule

// ===== rtl/mfrf_ram.sv =====
module mfrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mfrf_ctrl.sv =====
module mfrf_ctrl
    import mfrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.is_bcast ? ST_SCAN : ST_UPDATE;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CHECK:
            begin
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result not presented after commit");

    a_no_commit_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("commit overwrote a waiting result");

    a_scan_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |=> (state_reg == ST_SCAN || state_reg == ST_UPDATE))
        else $error("check state left to wrong state");
`endif

endmodule

// ===== rtl/mfrf_dp.sv =====
module mfrf_dp
    import mfrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_own_address,
    input  logic [ADDR_W-1:0] dst_address,
    input  logic [ADDR_W-1:0] src_address,
    input  logic [ADDR_W-1:0] final_dest,
    input  logic [ADDR_W-1:0] route_word,
    input  logic [TAG_W-1:0]  frame_tag,
    input  logic [POWER_W-1:0] signal_power,
    input  logic [LEN_W-1:0]  uplink_length,
    output logic [1:0]        action,
    output logic [ADDR_W-1:0] next_hop,
    output logic [LEN_W-1:0]  relay_length,
    output logic [ADDR_W-1:0] relay_delay,
    output logic              neighbor_added,
    output logic              route_changed
);

    logic [ADDR_W-1:0]  own_address_reg;
    logic [ADDR_W-1:0]  default_route_reg;
    logic [NB_CNT_W-1:0]  nb_count_reg;
    logic [TAG_CNT_W-1:0] tag_count_reg;

    logic [ADDR_W-1:0]  dst_reg, src_reg, fin_reg, route_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [POWER_W-1:0] power_reg;
    logic [LEN_W-1:0]   len_reg;

    logic [NB_CNT_W-1:0]  nb_idx_reg;
    logic [TAG_CNT_W-1:0] tag_idx_reg;
    logic nb_pend_reg, tag_pend_reg;
    logic nb_hit_reg, tag_hit_reg;

    logic [1:0]         action_reg;
    logic [ADDR_W-1:0]  next_hop_reg;
    logic [LEN_W-1:0]   relay_length_reg;
    logic [ADDR_W-1:0]  relay_delay_reg;
    logic               neighbor_added_reg;
    logic               route_changed_reg;

    logic [ADDR_W+POWER_W-1:0] nb_rd_data;
    logic [TAG_W-1:0]          tag_rd_data;
    logic nb_rd_en, tag_rd_en;
    logic is_own, is_bcast, bcast_only;
    logic nb_add, tag_new, tag_store, route_set;
    logic nb_room, tag_room;
    logic [LEN_W-1:0] len_sat;

    assign is_own     = (dst_reg == own_address_reg);
    assign is_bcast   = (dst_reg == BCAST_ADDR);
    assign bcast_only = is_bcast && !is_own;
    assign nb_room    = (nb_count_reg < NB_CNT_W'(NEIGHBOR_SLOTS));
    assign tag_room   = (tag_count_reg < TAG_CNT_W'(TAG_SLOTS));
    assign nb_add     = bcast_only && !nb_hit_reg && nb_room;
    assign tag_new    = bcast_only && !tag_hit_reg;
    assign tag_store  = tag_new && tag_room;
    assign route_set  = bcast_only && (fin_reg == own_address_reg);
    assign len_sat    = (len_reg > LEN_MAX) ? LEN_MAX : len_reg;

    assign nb_rd_en  = cmd.scan_en && (nb_idx_reg < nb_count_reg);
    assign tag_rd_en = cmd.scan_en && (tag_idx_reg < tag_count_reg);

    assign status.is_bcast  = bcast_only;
    assign status.scan_done = (nb_idx_reg == nb_count_reg) && !nb_pend_reg
                           && (tag_idx_reg == tag_count_reg) && !tag_pend_reg;

    mfrf_ram #(
        .WIDTH (ADDR_W + POWER_W),
        .DEPTH (NEIGHBOR_SLOTS)
    ) u_nb_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && nb_add),
        .wr_addr (nb_count_reg[NB_IDX_W-1:0]),
        .wr_data ({src_reg, power_reg}),
        .rd_en   (nb_rd_en),
        .rd_addr (nb_idx_reg[NB_IDX_W-1:0]),
        .rd_data (nb_rd_data)
    );

    mfrf_ram #(
        .WIDTH (TAG_W),
        .DEPTH (TAG_SLOTS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && tag_store),
        .wr_addr (tag_count_reg[TAG_IDX_W-1:0]),
        .wr_data (tag_reg),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_idx_reg[TAG_IDX_W-1:0]),
        .rd_data (tag_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg   <= OWN_RESET;
            default_route_reg <= ROUTE_RESET;
            nb_count_reg      <= '0;
            tag_count_reg     <= '0;
            nb_idx_reg        <= '0;
            tag_idx_reg       <= '0;
            nb_pend_reg       <= 1'b0;
            tag_pend_reg      <= 1'b0;
            nb_hit_reg        <= 1'b0;
            tag_hit_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                own_address_reg <= cfg_own_address;
            end
            if (cmd.load)
            begin
                nb_idx_reg   <= '0;
                tag_idx_reg  <= '0;
                nb_pend_reg  <= 1'b0;
                tag_pend_reg <= 1'b0;
                nb_hit_reg   <= 1'b0;
                tag_hit_reg  <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                nb_pend_reg  <= nb_rd_en;
                tag_pend_reg <= tag_rd_en;
                if (nb_rd_en)
                begin
                    nb_idx_reg <= nb_idx_reg + 1'b1;
                end
                if (tag_rd_en)
                begin
                    tag_idx_reg <= tag_idx_reg + 1'b1;
                end
                if (nb_pend_reg && (nb_rd_data[ADDR_W+POWER_W-1:POWER_W] == src_reg))
                begin
                    nb_hit_reg <= 1'b1;
                end
                if (tag_pend_reg && (tag_rd_data == tag_reg))
                begin
                    tag_hit_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                if (nb_add)
                begin
                    nb_count_reg <= nb_count_reg + 1'b1;
                end
                if (tag_store)
                begin
                    tag_count_reg <= tag_count_reg + 1'b1;
                end
                if (route_set)
                begin
                    default_route_reg <= route_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dst_reg   <= dst_address;
            src_reg   <= src_address;
            fin_reg   <= final_dest;
            route_reg <= route_word;
            tag_reg   <= frame_tag;
            power_reg <= signal_power;
            len_reg   <= uplink_length;
        end
        if (cmd.commit)
        begin
            neighbor_added_reg <= nb_add;
            route_changed_reg  <= route_set;
            if (is_own)
            begin
                action_reg       <= ACT_RELAY;
                next_hop_reg     <= default_route_reg;
                relay_length_reg <= len_sat;
                relay_delay_reg  <= '0;
            end
            else if (tag_new)
            begin
                action_reg       <= ACT_BCAST;
                next_hop_reg     <= BCAST_ADDR;
                relay_length_reg <= BCAST_LEN;
                relay_delay_reg  <= own_address_reg;
            end
            else
            begin
                action_reg       <= ACT_NONE;
                next_hop_reg     <= '0;
                relay_length_reg <= '0;
                relay_delay_reg  <= '0;
            end
        end
    end

    assign action         = action_reg;
    assign next_hop       = next_hop_reg;
    assign relay_length   = relay_length_reg;
    assign relay_delay    = relay_delay_reg;
    assign neighbor_added = neighbor_added_reg;
    assign route_changed  = route_changed_reg;

`ifndef SYNTHESIS
    a_nb_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nb_count_reg <= NB_CNT_W'(NEIGHBOR_SLOTS))
        else $error("neighbour count beyond table size");

    a_tag_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tag_count_reg <= TAG_CNT_W'(TAG_SLOTS))
        else $error("tag count beyond table size");

    a_own_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_own) |=> (!neighbor_added_reg && !route_changed_reg
                                    && $stable(nb_count_reg) && $stable(tag_count_reg)))
        else $error("table updated by a frame addressed to this node");

    a_scan_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_en |-> (nb_idx_reg <= nb_count_reg && tag_idx_reg <= tag_count_reg))
        else $error("scan index ran past filled entries");
`endif

endmodule

// ===== test/mesh_frame_relay_filter_core_test.sv =====
`timescale 1ns / 100ps

module mesh_frame_relay_filter_core_test;
    import mfrf_pkg::*;

    localparam int RANDOM_PER_PHASE = 180;
    localparam int PHASES           = 6;
    localparam int STUCK_LIMIT      = 3000;
    localparam int SETTLE_CYCLES    = 60;

    typedef struct packed {
        logic [ADDR_W-1:0]  dst;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  fin;
        logic [ADDR_W-1:0]  route;
        logic [TAG_W-1:0]   tag;
        logic [POWER_W-1:0] power;
        logic [LEN_W-1:0]   len;
    } frame_summary_t;

    typedef struct packed {
        action_t            act;
        logic [ADDR_W-1:0]  hop;
        logic [LEN_W-1:0]   rlen;
        logic [ADDR_W-1:0]  delay;
        logic               added;
        logic               changed;
    } relay_verdict_t;

    typedef struct packed {
        frame_summary_t f;
        logic           typed;
        relay_verdict_t v;
    } plan_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ADDR_W-1:0]  own_address = OWN_RESET;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ADDR_W-1:0]  dst_address = '0;
    logic [ADDR_W-1:0]  src_address = '0;
    logic [ADDR_W-1:0]  final_dest = '0;
    logic [ADDR_W-1:0]  route_word = '0;
    logic [TAG_W-1:0]   frame_tag = '0;
    logic [POWER_W-1:0] signal_power = '0;
    logic [LEN_W-1:0]   uplink_length = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         action;
    logic [ADDR_W-1:0]  next_hop;
    logic [LEN_W-1:0]   relay_length;
    logic [ADDR_W-1:0]  relay_delay;
    logic               neighbor_added;
    logic               route_changed;

    // predictor state
    logic [ADDR_W-1:0]  node_addr = OWN_RESET;
    logic [ADDR_W-1:0]  route_now = ROUTE_RESET;
    logic [ADDR_W-1:0]  nb_ids [NEIGHBOR_SLOTS];
    logic [POWER_W-1:0] nb_power [NEIGHBOR_SLOTS];
    int                 nb_fill = 0;
    logic [TAG_W-1:0]   tag_log [TAG_SLOTS];
    int                 tag_fill = 0;

    relay_verdict_t     expected_verdicts [$];
    plan_entry_t        directed_plan [$];
    int                 errors = 0;
    int                 results_seen = 0;

    int                 stall_mode = 0;
    int                 stall_left = 0;
    logic [7:0]         stall_bits = '0;

    mesh_frame_relay_filter_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .own_address    (own_address),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .dst_address    (dst_address),
        .src_address    (src_address),
        .final_dest     (final_dest),
        .route_word     (route_word),
        .frame_tag      (frame_tag),
        .signal_power   (signal_power),
        .uplink_length  (uplink_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .action         (action),
        .next_hop       (next_hop),
        .relay_length   (relay_length),
        .relay_delay    (relay_delay),
        .neighbor_added (neighbor_added),
        .route_changed  (route_changed)
    );

    always #6 clk = ~clk;

    task automatic predict_relay(input frame_summary_t f, output relay_verdict_t v);
        logic known;
        logic logged;
        v = '0;
        known = 1'b0;
        logged = 1'b0;
        if (f.dst == node_addr)
        begin
            v.act  = ACT_RELAY;
            v.hop  = route_now;
            v.rlen = (f.len > LEN_MAX) ? LEN_MAX : f.len;
        end
        else if (f.dst == BCAST_ADDR)
        begin
            for (int i = 0; i < nb_fill; i++)
                if (nb_ids[i] == f.src)
                    known = 1'b1;
            if (!known && nb_fill < NEIGHBOR_SLOTS)
            begin
                nb_ids[nb_fill]   = f.src;
                nb_power[nb_fill] = f.power;
                nb_fill++;
                v.added = 1'b1;
            end
            if (f.fin == node_addr)
            begin
                route_now = f.route;
                v.changed = 1'b1;
            end
            for (int i = 0; i < tag_fill; i++)
                if (tag_log[i] == f.tag)
                    logged = 1'b1;
            if (!logged)
            begin
                if (tag_fill < TAG_SLOTS)
                begin
                    tag_log[tag_fill] = f.tag;
                    tag_fill++;
                end
                v.act   = ACT_BCAST;
                v.hop   = BCAST_ADDR;
                v.rlen  = BCAST_LEN;
                v.delay = node_addr;
            end
        end
    endtask

    function automatic frame_summary_t random_frame();
        frame_summary_t f;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            f.dst = node_addr;
        else if (pick < 80)
            f.dst = BCAST_ADDR;
        else
            f.dst = 16'($urandom);
        if (nb_fill != 0 && $urandom_range(0, 1) == 1)
            f.src = nb_ids[$urandom_range(0, nb_fill - 1)];
        else
            f.src = 16'($urandom);
        f.fin   = ($urandom_range(0, 9) < 4) ? node_addr : 16'($urandom);
        f.route = 16'($urandom);
        if (tag_fill != 0 && $urandom_range(0, 1) == 1)
            f.tag = tag_log[$urandom_range(0, tag_fill - 1)];
        else
            f.tag = 8'($urandom);
        f.power = 8'($urandom);
        if ($urandom_range(0, 4) != 0)
            f.len = 7'($urandom_range(0, 64));
        else
            f.len = 7'($urandom_range(65, 127));
        return f;
    endfunction

    task automatic plan_typed(input logic [15:0] dst, src, fin, route,
                              input logic [7:0] tag, power, input logic [6:0] len,
                              input action_t act, input logic [15:0] hop,
                              input logic [6:0] rlen, input logic [15:0] delay,
                              input logic added, changed);
        plan_entry_t e;
        e.f       = {dst, src, fin, route, tag, power, len};
        e.typed   = 1'b1;
        e.v       = {act, hop, rlen, delay, added, changed};
        directed_plan.push_back(e);
    endtask

    task automatic plan_open(input logic [15:0] dst, src, fin, route,
                             input logic [7:0] tag, power, input logic [6:0] len);
        plan_entry_t e;
        e.f     = {dst, src, fin, route, tag, power, len};
        e.typed = 1'b0;
        e.v     = '0;
        directed_plan.push_back(e);
    endtask

    task automatic send_frame(input frame_summary_t f, input logic typed,
                              input relay_verdict_t typed_v);
        relay_verdict_t v;
        @(negedge clk);
        in_valid      <= 1'b1;
        dst_address   <= f.dst;
        src_address   <= f.src;
        final_dest    <= f.fin;
        route_word    <= f.route;
        frame_tag     <= f.tag;
        signal_power  <= f.power;
        uplink_length <= f.len;
        do
            @(posedge clk);
        while (in_stall);
        predict_relay(f, v);
        expected_verdicts.push_back(typed ? typed_v : v);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) @(negedge clk) in_valid <= 1'b0;
    endtask

    task automatic drain_and_settle(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_own(input logic [ADDR_W-1:0] addr);
        @(negedge clk);
        cfg_valid   <= 1'b1;
        own_address <= addr;
        do
            @(posedge clk);
        while (!cfg_ready);
        node_addr = addr;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [15:0] want, got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: result %0d %s expected %h, actual %h",
                     $time, results_seen, what, want, got);
        end
    endtask

    always @(negedge clk)
    begin : stall_pattern_gen
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
            stall_bits <= 8'($urandom) & 8'hFE;
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= stall_bits[stall_left % 8];
        endcase
    end

    always @(posedge clk)
    begin : result_check
        relay_verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t ns: result %0d expected none, actual action %h hop %h",
                         $time, results_seen, action, next_hop);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                check_field("action", 16'(want.act), 16'(action));
                check_field("next_hop", want.hop, next_hop);
                check_field("relay_length", 16'(want.rlen), 16'(relay_length));
                check_field("relay_delay", want.delay, relay_delay);
                check_field("neighbor_added", 16'(want.added), 16'(neighbor_added));
                check_field("route_changed", 16'(want.changed), 16'(route_changed));
            end
            results_seen++;
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("mesh_frame_relay_filter_core_test: errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0] own_plan [PHASES];
        int burst;
        int gap;
        own_plan[0] = BCAST_ADDR;
        own_plan[1] = 16'h0000;
        own_plan[2] = 16'($urandom);
        own_plan[3] = 16'($urandom);
        own_plan[4] = OWN_RESET;
        own_plan[5] = 16'($urandom);
        burst = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        //          dst       src       fin       route     tag    pwr    len
        plan_typed(16'h0001, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 7'd0,
                   ACT_RELAY, 16'h0002, 7'd0, 16'h0000, 1'b0, 1'b0);
        plan_typed(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 7'd64,
                   ACT_RELAY, 16'h0002, 7'd64, 16'h0000, 1'b0, 1'b0);
        plan_typed(16'h0001, 16'h1234, 16'h5678, 16'h9ABC, 8'h5A, 8'hA5, 7'd127,
                   ACT_RELAY, 16'h0002, 7'd64, 16'h0000, 1'b0, 1'b0);
        plan_typed(16'h0001, 16'hA5A5, 16'h0001, 16'h0F0F, 8'hC3, 8'h3C, 7'd65,
                   ACT_RELAY, 16'h0002, 7'd64, 16'h0000, 1'b0, 1'b0);
        plan_typed(16'h0000, 16'h0001, 16'h0001, 16'h7777, 8'h01, 8'h01, 7'd3,
                   ACT_NONE, 16'h0000, 7'd0, 16'h0000, 1'b0, 1'b0);
        plan_typed(16'hFFFE, 16'h0002, 16'h0001, 16'h8888, 8'h02, 8'h02, 7'd7,
                   ACT_NONE, 16'h0000, 7'd0, 16'h0000, 1'b0, 1'b0);
        plan_typed(16'h1234, 16'h0003, 16'h0001, 16'h9999, 8'h03, 8'h03, 7'd9,
                   ACT_NONE, 16'h0000, 7'd0, 16'h0000, 1'b0, 1'b0);
        // first broadcast: new sender, unseen tag, not for this node
        plan_typed(16'hFFFF, 16'hFFFF, 16'h0000, 16'h1111, 8'h00, 8'hFF, 7'd0,
                   ACT_BCAST, 16'hFFFF, 7'd5, 16'h0001, 1'b1, 1'b0);
        plan_typed(16'hFFFF, 16'hFFFF, 16'h0000, 16'h2222, 8'h00, 8'h80, 7'd1,
                   ACT_NONE, 16'h0000, 7'd0, 16'h0000, 1'b0, 1'b0);
        plan_typed(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 8'hFF, 8'h00, 7'd127,
                   ACT_BCAST, 16'hFFFF, 7'd5, 16'h0001, 1'b1, 1'b1);
        plan_typed(16'h0001, 16'h4444, 16'h4444, 16'h4444, 8'h44, 8'h44, 7'd10,
                   ACT_RELAY, 16'hFFFF, 7'd10, 16'h0000, 1'b0, 1'b0);
        // seen tag still rewrites the route
        plan_typed(16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 8'hFF, 8'h11, 7'd20,
                   ACT_NONE, 16'h0000, 7'd0, 16'h0000, 1'b0, 1'b1);
        // route rewritten with the value it already holds
        plan_typed(16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 8'h7F, 8'h22, 7'd30,
                   ACT_BCAST, 16'hFFFF, 7'd5, 16'h0001, 1'b0, 1'b1);
        plan_typed(16'h0001, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 7'd64,
                   ACT_RELAY, 16'h0000, 7'd64, 16'h0000, 1'b0, 1'b0);
        // fill the neighbour table
        plan_open(16'hFFFF, 16'hAAAA, 16'h5555, 16'h0101, 8'h01, 8'h10, 7'd11);
        plan_open(16'hFFFF, 16'h5555, 16'hAAAA, 16'h0202, 8'h02, 8'h20, 7'd12);
        plan_open(16'hFFFF, 16'h0F0F, 16'h0001, 16'h0303, 8'h03, 8'h30, 7'd13);
        plan_open(16'hFFFF, 16'hF0F0, 16'h0002, 16'h0404, 8'h04, 8'h40, 7'd14);
        plan_open(16'hFFFF, 16'h00FF, 16'h0003, 16'h0505, 8'h05, 8'h50, 7'd15);
        plan_open(16'hFFFF, 16'hFF00, 16'h0004, 16'h0606, 8'h06, 8'h60, 7'd16);
        // table full: an unknown sender is dropped
        plan_typed(16'hFFFF, 16'h1357, 16'h0000, 16'h0707, 8'h80, 8'h70, 7'd17,
                   ACT_BCAST, 16'hFFFF, 7'd5, 16'h0001, 1'b0, 1'b0);
        plan_open(16'hFFFF, 16'hAAAA, 16'h0001, 16'h4242, 8'h80, 8'h90, 7'd18);
        plan_open(16'h0001, 16'hBBBB, 16'hCCCC, 16'hDDDD, 8'hEE, 8'hEE, 7'd40);

        foreach (directed_plan[i])
            send_frame(directed_plan[i].f, directed_plan[i].typed, directed_plan[i].v);
        drain_and_settle(8);

        for (int p = 0; p < PHASES; p++)
        begin
            write_own(own_plan[p]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (burst == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if ($urandom_range(0, 19) == 0)
                        gap = $urandom_range(20, 60);
                    idle_cycles(gap);
                    burst = $urandom_range(1, 24);
                end
                send_frame(random_frame(), 1'b0, '0);
                burst--;
                // hold off until every transfer in flight has come back
                if ((p == 0 && n == RANDOM_PER_PHASE / 2) || $urandom_range(0, 199) == 0)
                    drain_and_settle(0);
            end
            drain_and_settle(8);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_verdicts.size() == 0)
            $display("mesh_frame_relay_filter_core_test: clean");
        else
            $display("mesh_frame_relay_filter_core_test: errors");
        $finish;
    end

endmodule
